// ===== rtl/gsp_pkg.sv =====
// shared types and constants of the graph shortest path core
// no dependencies; used by the interfaces, controller, datapath and top level
package gsp_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_DEGREE  = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int CMD_W    = 2;
    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 16;
    localparam int PDIST_W  = 22;
    localparam int DIST_W   = 23;
    localparam int PREV_W   = NODE_W + 1;

    localparam logic [PREV_W-1:0]  NO_HOP     = PREV_W'(64);
    localparam logic [PDIST_W-1:0] PDIST_MAX  = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_PATH  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_NO_EDGE = 3'd2,
        ST_UNREACH = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_FIND_RD,
        S_FIND_CMP,
        S_EMIT1,
        S_PINIT,
        S_SCAN,
        S_PICK,
        S_REL_RD,
        S_REL_T,
        S_REL_UPD,
        S_WALK1,
        S_WALK,
        S_WALK_NX,
        S_EP_RD,
        S_EP_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    ld_in;
        logic    mark_known;
        logic    deg_rd_a;
        logic    deg_rd_best;
        logic    k_clr;
        logic    k_inc;
        logic    edge_rd_find;
        logic    edge_rd_rel;
        logic    edge_upd;
        logic    edge_add;
        logic    st_ld;
        logic    found_ld;
        t_status st_code;
        logic    p_init;
        logic    scan_clr;
        logic    scan_step;
        logic    scan_last;
        logic    settle;
        logic    nd_ld;
        logic    relax;
        logic    walk_rd;
        logic    walk_dist;
        logic    walk_push;
        logic    walk_next;
        logic    ep_init;
        logic    ep_rd;
        logic    ep_dec;
        logic    out_single;
        logic    out_path;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        t_cmd cmd;
        logic range_bad;
        logic known_ok;
        logic deg_end;
        logic deg_full;
        logic found;
        logic scan_end;
        logic best_vld;
        logic dst_settled;
        logic walk_end;
        logic ep_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/gsp_ifs.sv =====
// request and response channel interfaces of the graph shortest path core
// depends on gsp_pkg for field widths
interface gsp_req_if import gsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, command, from_node, to_node, edge_weight, input ready);
    modport sink   (input valid, command, from_node, to_node, edge_weight, output ready);
endinterface

interface gsp_rsp_if import gsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_weight;
    logic [PDIST_W-1:0]  path_distance;
    logic [NODE_W-1:0]   path_node;
    logic                last_item;

    modport source (output valid, status, found_weight, path_distance, path_node, last_item,
                    input ready);
    modport sink   (input valid, status, found_weight, path_distance, path_node, last_item,
                    output ready);
endinterface

// ===== rtl/weighted_graph_shortest_path_core.sv =====
// top level of the graph shortest path core: sequencer plus datapath
// depends on gsp_pkg, gsp_ifs, gsp_ctrl and gsp_dp
//
//   channel  dir  modport  payload
//   i_req    in   sink     command, from_node, to_node, edge_weight
//   o_rsp    out  source   status, found_weight, path_distance, path_node, last_item
//
// edge add/query: searches the stored edges of the source node one by one, reading and then comparing each
// path query: per settled node one scan over all MAX_NODES entries of the distance memory,
// then a read, a distance sum and an update per outgoing edge; then the path is walked back
// from the destination onto a stack and emitted node by node in forward order
// one command at a time; results sit in an output register while the next word is taken
// reset clears known nodes, degree valid bits, output valid and the sequencer; no sweep
module weighted_graph_shortest_path_core import gsp_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsp_req_if.sink   i_req,
    gsp_rsp_if.source o_rsp
);

    t_ctl ctl;
    t_sts sts;

    gsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    gsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_DEGREE  (MAX_DEGREE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== rtl/gsp_ctrl.sv =====
// command sequencer of the graph shortest path core
// depends on gsp_pkg; drives the datapath through t_ctl and reads t_sts
module gsp_ctrl import gsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.cmd == CMD_NONE) begin
                    n_state = S_IDLE;
                end else if (i_sts.range_bad) begin
                    n_state = S_EMIT1;
                end else if (i_sts.cmd == CMD_ADD) begin
                    n_state = S_FIND_RD;
                end else if (!i_sts.known_ok) begin
                    n_state = S_EMIT1;
                end else if (i_sts.cmd == CMD_QUERY) begin
                    n_state = S_FIND_RD;
                end else begin
                    n_state = S_PINIT;
                end
            end
            S_FIND_RD: begin
                n_state = i_sts.deg_end ? S_EMIT1 : S_FIND_CMP;
            end
            S_FIND_CMP: begin
                n_state = i_sts.found ? S_EMIT1 : S_FIND_RD;
            end
            S_EMIT1: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PINIT: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.best_vld) begin
                    n_state = S_REL_RD;
                end else if (i_sts.dst_settled) begin
                    n_state = S_WALK1;
                end else begin
                    n_state = S_EMIT1;
                end
            end
            S_REL_RD: begin
                n_state = i_sts.deg_end ? S_SCAN : S_REL_T;
            end
            S_REL_T: begin
                n_state = S_REL_UPD;
            end
            S_REL_UPD: begin
                n_state = S_REL_RD;
            end
            S_WALK1: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                n_state = S_WALK_NX;
            end
            S_WALK_NX: begin
                n_state = i_sts.walk_end ? S_EP_RD : S_WALK;
            end
            S_EP_RD: begin
                n_state = S_EP_OUT;
            end
            S_EP_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.ep_zero ? S_IDLE : S_EP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl         = '0;
        o_ctl.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.ld_in = 1'b1;
            end
            S_CHECK: begin
                if (i_sts.cmd == CMD_NONE) begin
                    o_ctl.ld_in = 1'b0;
                end else if (i_sts.range_bad) begin
                    o_ctl.st_ld   = 1'b1;
                    o_ctl.st_code = ST_UNKNOWN;
                end else if (i_sts.cmd == CMD_ADD) begin
                    o_ctl.mark_known = 1'b1;
                    o_ctl.deg_rd_a   = 1'b1;
                    o_ctl.k_clr      = 1'b1;
                end else if (!i_sts.known_ok) begin
                    o_ctl.st_ld   = 1'b1;
                    o_ctl.st_code = ST_UNKNOWN;
                end else if (i_sts.cmd == CMD_QUERY) begin
                    o_ctl.deg_rd_a = 1'b1;
                    o_ctl.k_clr    = 1'b1;
                end else begin
                    o_ctl.ld_in = 1'b0;
                end
            end
            S_FIND_RD: begin
                if (!i_sts.deg_end) begin
                    o_ctl.edge_rd_find = 1'b1;
                end else if (i_sts.cmd == CMD_QUERY) begin
                    o_ctl.st_ld   = 1'b1;
                    o_ctl.st_code = ST_NO_EDGE;
                end else if (i_sts.deg_full) begin
                    o_ctl.st_ld   = 1'b1;
                    o_ctl.st_code = ST_FULL;
                end else begin
                    o_ctl.edge_add = 1'b1;
                    o_ctl.st_ld    = 1'b1;
                end
            end
            S_FIND_CMP: begin
                if (!i_sts.found) begin
                    o_ctl.k_inc = 1'b1;
                end else begin
                    o_ctl.st_ld    = 1'b1;
                    o_ctl.edge_upd = (i_sts.cmd == CMD_ADD);
                    o_ctl.found_ld = (i_sts.cmd == CMD_QUERY);
                end
            end
            S_EMIT1: begin
                o_ctl.out_single = i_sts.out_free;
            end
            S_PINIT: begin
                o_ctl.p_init   = 1'b1;
                o_ctl.scan_clr = 1'b1;
            end
            S_SCAN: begin
                o_ctl.scan_step = !i_sts.scan_end;
                o_ctl.scan_last = i_sts.scan_end;
            end
            S_PICK: begin
                if (i_sts.best_vld) begin
                    o_ctl.settle      = 1'b1;
                    o_ctl.deg_rd_best = 1'b1;
                    o_ctl.k_clr       = 1'b1;
                end else if (i_sts.dst_settled) begin
                    o_ctl.walk_rd = 1'b1;
                end else begin
                    o_ctl.st_ld   = 1'b1;
                    o_ctl.st_code = ST_UNREACH;
                end
            end
            S_REL_RD: begin
                o_ctl.edge_rd_rel = !i_sts.deg_end;
                o_ctl.scan_clr    = i_sts.deg_end;
            end
            S_REL_T: begin
                o_ctl.nd_ld = 1'b1;
            end
            S_REL_UPD: begin
                o_ctl.relax = 1'b1;
                o_ctl.k_inc = 1'b1;
            end
            S_WALK1: begin
                o_ctl.walk_dist = 1'b1;
            end
            S_WALK: begin
                o_ctl.walk_push = 1'b1;
            end
            S_WALK_NX: begin
                o_ctl.walk_next = 1'b1;
                o_ctl.ep_init   = i_sts.walk_end;
            end
            S_EP_RD: begin
                o_ctl.ep_rd = 1'b1;
            end
            S_EP_OUT: begin
                o_ctl.out_path = i_sts.out_free;
                o_ctl.ep_dec   = i_sts.out_free && !i_sts.ep_zero;
            end
            default: begin
                o_ctl.ld_in = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/gsp_dp.sv =====
// datapath of the graph shortest path core: graph stores, path scratch memories,
// scan and relax logic, output register; depends on gsp_pkg and gsp_ifs
module gsp_dp import gsp_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    output t_sts      o_sts,
    gsp_req_if.sink   i_req,
    gsp_rsp_if.source o_rsp
);

    localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW_I = AW + 1;
    localparam int DG_W = $clog2(MAX_DEGREE + 1);
    localparam int EA_W = $clog2(MAX_NODES * MAX_DEGREE);
    localparam int ESZ  = MAX_NODES * MAX_DEGREE;
    localparam int CW   = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

    // latched command
    t_cmd              r_cmd;
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic [CW-1:0]     r_w;

    logic [MAX_NODES-1:0] r_known;
    logic [MAX_NODES-1:0] r_deg_vld;
    logic [MAX_NODES-1:0] r_reached;
    logic [MAX_NODES-1:0] r_settled;

    logic [DG_W-1:0]   deg_mem [MAX_NODES];
    logic [NODE_W-1:0] tgt_mem [ESZ];
    logic [CW-1:0]     cost_mem [ESZ];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [PREV_W-1:0] prev_mem [MAX_NODES];
    logic [NODE_W-1:0] stack_mem [MAX_NODES];

    logic [DG_W-1:0]   r_deg_q;
    logic              r_deg_v;
    logic [NODE_W-1:0] r_tgt_q;
    logic [CW-1:0]     r_cost_q;
    logic [DIST_W-1:0] r_dist_q;
    logic [PREV_W-1:0] r_prev_q;
    logic [NODE_W-1:0] r_stack_q;

    logic [DG_W-1:0]   r_k;
    logic [CW_I-1:0]   r_i;
    logic [AW-1:0]     r_rd_idx;
    logic              r_rd_vld;
    logic              r_best_vld;
    logic [AW-1:0]     r_best;
    logic [DIST_W-1:0] r_best_d;
    logic [NODE_W-1:0] r_t;
    logic [DIST_W-1:0] r_nd;
    logic [PDIST_W-1:0] r_pdist;
    logic [NODE_W-1:0] r_cur;
    logic [CW_I-1:0]   r_n;
    logic [AW-1:0]     r_idx;

    t_status           r_st;
    logic [CW-1:0]     r_found;

    logic               r_ovld;
    t_status            r_o_status;
    logic [FOUND_W-1:0] r_o_found;
    logic [PDIST_W-1:0] r_o_dist;
    logic [NODE_W-1:0]  r_o_node;
    logic               r_o_last;

    logic [AW-1:0]     a_idx;
    logic [AW-1:0]     b_idx;
    logic [DG_W-1:0]   deg;
    logic [EA_W-1:0]   base_a;
    logic [EA_W-1:0]   base_best;
    logic [EA_W-1:0]   e_ra;
    logic [EA_W-1:0]   e_wa;
    logic              e_re;
    logic [AW-1:0]     deg_ra;
    logic [AW-1:0]     dist_ra;
    logic              dist_re;
    logic [AW-1:0]     dist_wa;
    logic [DIST_W-1:0] dist_wd;
    logic              dist_we;
    logic              cand;
    logic              relax_ok;
    logic              in_fire;
    logic              out_load;
    logic              out_free;

    assign a_idx     = r_a[AW-1:0];
    assign b_idx     = r_b[AW-1:0];
    assign deg       = r_deg_v ? r_deg_q : '0;
    assign base_a    = EA_W'(a_idx) * EA_W'(MAX_DEGREE);
    assign base_best = EA_W'(r_best) * EA_W'(MAX_DEGREE);
    assign in_fire   = i_ctl.ld_in && i_req.valid;
    assign out_load  = i_ctl.out_single || i_ctl.out_path;
    assign out_free  = !r_ovld || o_rsp.ready;
    assign i_req.ready = i_ctl.ld_in;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= t_cmd'(i_req.command);
            r_a   <= i_req.from_node;
            r_b   <= i_req.to_node;
            r_w   <= i_req.edge_weight[CW-1:0];
        end
    end

    // known nodes and degree valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known   <= '0;
            r_deg_vld <= '0;
        end else begin
            if (i_ctl.mark_known) begin
                r_known[a_idx] <= 1'b1;
                r_known[b_idx] <= 1'b1;
            end
            if (i_ctl.edge_add) begin
                r_deg_vld[a_idx] <= 1'b1;
            end
        end
    end

    // out-degree store
    assign deg_ra = i_ctl.deg_rd_best ? r_best : a_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.edge_add) begin
            deg_mem[a_idx] <= deg + DG_W'(1);
        end
        if (i_ctl.deg_rd_a || i_ctl.deg_rd_best) begin
            r_deg_q <= deg_mem[deg_ra];
            r_deg_v <= r_deg_vld[deg_ra];
        end
    end

    // edge stores
    assign e_ra = i_ctl.edge_rd_rel ? (base_best + EA_W'(r_k)) : (base_a + EA_W'(r_k));
    assign e_re = i_ctl.edge_rd_find || i_ctl.edge_rd_rel;
    assign e_wa = i_ctl.edge_add ? (base_a + EA_W'(deg)) : (base_a + EA_W'(r_k));

    always_ff @(posedge i_clk) begin
        if (i_ctl.edge_add) begin
            tgt_mem[e_wa] <= r_b;
        end
        if (i_ctl.edge_add || i_ctl.edge_upd) begin
            cost_mem[e_wa] <= r_w;
        end
        if (e_re) begin
            r_tgt_q  <= tgt_mem[e_ra];
            r_cost_q <= cost_mem[e_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.k_clr) begin
            r_k <= '0;
        end else if (i_ctl.k_inc) begin
            r_k <= r_k + DG_W'(1);
        end
    end

    // tentative distance and previous hop stores
    always_comb begin
        priority if (i_ctl.nd_ld) begin
            dist_ra = r_tgt_q[AW-1:0];
        end else if (i_ctl.walk_rd) begin
            dist_ra = b_idx;
        end else begin
            dist_ra = r_i[AW-1:0];
        end
    end
    assign dist_re  = i_ctl.scan_step || i_ctl.nd_ld || i_ctl.walk_rd;
    assign relax_ok = !r_reached[r_t[AW-1:0]] || (r_nd < r_dist_q);
    assign dist_we  = i_ctl.p_init || (i_ctl.relax && relax_ok);
    assign dist_wa  = i_ctl.p_init ? a_idx : r_t[AW-1:0];
    assign dist_wd  = i_ctl.p_init ? '0 : r_nd;

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
            prev_mem[dist_wa] <= i_ctl.p_init ? NO_HOP : PREV_W'(r_best);
        end
        if (dist_re) begin
            r_dist_q <= dist_mem[dist_ra];
        end
        if (i_ctl.walk_push) begin
            r_prev_q <= prev_mem[r_cur[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.p_init) begin
            r_reached        <= '0;
            r_reached[a_idx] <= 1'b1;
            r_settled        <= '0;
        end else begin
            if (i_ctl.relax && relax_ok) begin
                r_reached[r_t[AW-1:0]] <= 1'b1;
            end
            if (i_ctl.settle) begin
                r_settled[r_best] <= 1'b1;
            end
        end
    end

    // minimum search: one read issued per cycle, its result evaluated in the next cycle
    assign cand = r_rd_vld && r_reached[r_rd_idx] && !r_settled[r_rd_idx]
               && (!r_best_vld || (r_dist_q < r_best_d));

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_clr) begin
            r_i        <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_ctl.scan_step || i_ctl.scan_last) begin
            if (cand) begin
                r_best_vld <= 1'b1;
                r_best     <= r_rd_idx;
                r_best_d   <= r_dist_q;
            end
            r_rd_vld <= i_ctl.scan_step;
            r_rd_idx <= r_i[AW-1:0];
            if (i_ctl.scan_step) begin
                r_i <= r_i + CW_I'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.nd_ld) begin
            r_t  <= r_tgt_q;
            r_nd <= r_best_d + DIST_W'(r_cost_q);
        end
    end

    // path walk back from the destination, then replay in forward order
    always_ff @(posedge i_clk) begin
        if (i_ctl.walk_dist) begin
            r_pdist <= (r_dist_q > DIST_W'(PDIST_MAX)) ? PDIST_MAX : r_dist_q[PDIST_W-1:0];
            r_cur   <= r_b;
            r_n     <= '0;
        end else if (i_ctl.walk_push) begin
            stack_mem[r_n[AW-1:0]] <= r_cur;
            r_n <= r_n + CW_I'(1);
        end else if (i_ctl.walk_next) begin
            r_cur <= r_prev_q[NODE_W-1:0];
        end
        if (i_ctl.ep_init) begin
            r_idx <= r_n[AW-1:0] - AW'(1);
        end else if (i_ctl.ep_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_ctl.ep_rd) begin
            r_stack_q <= stack_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_ld) begin
            r_st    <= i_ctl.st_code;
            r_found <= i_ctl.found_ld ? r_cost_q : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_single) begin
            r_o_status <= r_st;
            r_o_found  <= FOUND_W'(r_found);
            r_o_dist   <= '0;
            r_o_node   <= '0;
            r_o_last   <= 1'b1;
        end else if (i_ctl.out_path) begin
            r_o_status <= ST_OK;
            r_o_found  <= '0;
            r_o_dist   <= r_pdist;
            r_o_node   <= r_stack_q;
            r_o_last   <= (r_idx == '0);
        end
    end

    assign o_rsp.valid         = r_ovld;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.found_weight  = r_o_found;
    assign o_rsp.path_distance = r_o_dist;
    assign o_rsp.path_node     = r_o_node;
    assign o_rsp.last_item     = r_o_last;

    always_comb begin
        o_sts             = '0;
        o_sts.in_valid    = i_req.valid;
        o_sts.cmd         = r_cmd;
        o_sts.range_bad   = ({1'b0, r_a} >= (NODE_W + 1)'(MAX_NODES))
                         || ({1'b0, r_b} >= (NODE_W + 1)'(MAX_NODES));
        o_sts.known_ok    = r_known[a_idx] && r_known[b_idx];
        o_sts.deg_end     = (r_k == deg);
        o_sts.deg_full    = (deg == DG_W'(MAX_DEGREE));
        o_sts.found       = (r_tgt_q == r_b);
        o_sts.scan_end    = (r_i == CW_I'(MAX_NODES));
        o_sts.best_vld    = r_best_vld;
        o_sts.dst_settled = r_settled[b_idx];
        o_sts.walk_end    = (r_prev_q >= PREV_W'(MAX_NODES)) || (r_n == CW_I'(MAX_NODES));
        o_sts.ep_zero     = (r_idx == '0);
        o_sts.out_free    = out_free;
    end

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a word not yet taken");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.scan_step |-> (r_i < CW_I'(MAX_NODES)))
        else $error("minimum scan ran past the last node");
    a_settle_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.settle |-> (r_best_vld && !r_settled[r_best] && r_reached[r_best]))
        else $error("settled a node that was not an open candidate");
    a_edge_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_re |-> (r_k < deg))
        else $error("edge read beyond the adjacency list");
`endif

endmodule
